@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// concurrent property checks, empty when synthesized
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/bcht_pkg.sv @@
// ---------------------------------------------------------------------------
// bcht_pkg
// types, constants and helpers of the battery cycle history tracker
// ---------------------------------------------------------------------------
package bcht_pkg;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_POWER  = 2'd1;
    localparam logic [1:0] KIND_COMMIT = 2'd2;

    localparam logic [1:0] REG_SAMPLE_DROP   = 2'd0;
    localparam logic [1:0] REG_OBSERVED_RISE = 2'd1;
    localparam logic [1:0] REG_INFERRED_RISE = 2'd2;

    localparam logic [6:0] SAMPLE_DROP_RST   = 7'd5;
    localparam logic [6:0] OBSERVED_RISE_RST = 7'd2;
    localparam logic [6:0] INFERRED_RISE_RST = 7'd8;

    localparam logic [7:0]  PCT_NONE   = 8'd255;
    localparam logic [7:0]  PCT_MAX    = 8'd100;
    localparam logic [15:0] U16_MAX    = 16'hFFFF;
    localparam logic [31:0] MS_PER_SEC = 32'd1000;

    // x / 1000 = (x * MAGIC_MS) >> 38, x / 60 = (x * MAGIC_MIN) >> 37, exact for 32 bits
    localparam logic [63:0] MAGIC_MS  = 64'd274877907;
    localparam int          MS_SHIFT  = 38;
    localparam logic [63:0] MAGIC_MIN = 64'd2290649225;
    localparam int          MIN_SHIFT = 37;

    localparam int SAMPLE_SLOTS_DEF = 32;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic        external_power;
        logic        measure_ok;
        logic [7:0]  percent;
        logic        day_ok;
        logic [31:0] day_index;
    } item_t;

    typedef struct packed {
        item_t       item;
        logic [31:0] sess_secs;
        logic [31:0] since_unplug;
        logic        unplugged;
        logic        saw_external;
    } session_t;

    typedef struct packed {
        logic [5:0]  pad;
        logic        start_day_known;
        logic [31:0] start_day;
        logic        measure_error;
        logic [15:0] sleep_count;
        logic        charge_pending;
        logic        cycle_confirmed;
        logic        cycle_began;
        logic [7:0]  previous_percent;
        logic [6:0]  newest_percent;
        logic [15:0] newest_minutes;
        logic [5:0]  sample_count;
        logic [31:0] active_seconds;
    } result_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ hdl/battery_cycle_history_tracker_top.sv @@
// ---------------------------------------------------------------------------
// battery_cycle_history_tracker_top
// on-battery time accounting and discharge cycle history, one result per event
// ---------------------------------------------------------------------------
// pipeline: input register s1_reg, session stage s2_reg, cycle stage out_reg
// throughput: one transaction per cycle unless m_tready back-pressure stalls it; the session
//   loop (divide by 1000) and the cycle loop (divide by 60) each update their state combinationally
// reset: asynchronous, clears all tracking state, thresholds back to 5/2/8,
//   no clearing pass, items accepted right after reset
`include "assert_macros.svh"

module battery_cycle_history_tracker_top #(
    parameter int SAMPLE_SLOTS = bcht_pkg::SAMPLE_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // now_ms, external_power, measure_ok, percent, day_ok, day_index, zero pad
    input  logic [79:0]  s_tdata,
    // kind
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // active_seconds, sample_count, newest_minutes, newest_percent,
    // previous_percent, cycle_began, cycle_confirmed, charge_pending,
    // sleep_count, measure_error, start_day, start_day_known, zero pad
    output logic [127:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [6:0]   cfg_data
);

    localparam int CNT_W = $clog2(SAMPLE_SLOTS + 1);

    // configuration
    logic [6:0] drop_reg, orise_reg, irise_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg  <= bcht_pkg::SAMPLE_DROP_RST;
            orise_reg <= bcht_pkg::OBSERVED_RISE_RST;
            irise_reg <= bcht_pkg::INFERRED_RISE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bcht_pkg::REG_SAMPLE_DROP:   drop_reg  <= cfg_data;
                bcht_pkg::REG_OBSERVED_RISE: orise_reg <= cfg_data;
                bcht_pkg::REG_INFERRED_RISE: irise_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // pipeline control
    logic s1_v_reg, s2_v_reg, out_v_reg;
    logic out_ok, b_fire, s2_ok, a_fire, in_fire;

    assign out_ok   = !out_v_reg || m_tready;
    assign b_fire   = s2_v_reg && out_ok;
    assign s2_ok    = !s2_v_reg || b_fire;
    assign a_fire   = s1_v_reg && s2_ok;
    assign s_tready = !s1_v_reg || a_fire;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_v_reg <= 1'b1;
            else if (a_fire)
                s1_v_reg <= 1'b0;
            if (a_fire)
                s2_v_reg <= 1'b1;
            else if (b_fire)
                s2_v_reg <= 1'b0;
            if (b_fire)
                out_v_reg <= 1'b1;
            else if (m_tready)
                out_v_reg <= 1'b0;
        end
    end

    // input register
    bcht_pkg::item_t in_item, s1_reg;

    assign in_item.kind           = s_tuser;
    assign in_item.now_ms         = s_tdata[31:0];
    assign in_item.external_power = s_tdata[32];
    assign in_item.measure_ok     = s_tdata[33];
    assign in_item.percent        = s_tdata[41:34];
    assign in_item.day_ok         = s_tdata[42];
    assign in_item.day_index      = s_tdata[74:43];

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_reg <= in_item;
    end

    // session stage: power state and on-battery accrual
    logic        running_reg, on_ext_reg, saw_reg, unpl_reg;
    logic [31:0] last_reg, sess_reg, since_reg;
    logic        running_next, on_ext_next, saw_next, unpl_next;
    logic [31:0] last_next, sess_next, since_next;
    logic [31:0] diff, secs, acc_sess, acc_since, acc_last;
    logic [63:0] prod_ms;
    bcht_pkg::session_t s2_next, s2_reg;

    always_comb
    begin
        diff      = s1_reg.now_ms - last_reg;
        prod_ms   = 64'(diff) * bcht_pkg::MAGIC_MS;
        secs      = 32'(prod_ms >> bcht_pkg::MS_SHIFT);
        acc_sess  = on_ext_reg ? sess_reg : bcht_pkg::sat_add32(sess_reg, secs);
        acc_since = (!on_ext_reg && unpl_reg) ? bcht_pkg::sat_add32(since_reg, secs)
                                              : since_reg;
        acc_last  = on_ext_reg ? s1_reg.now_ms
                               : last_reg + 32'(secs * bcht_pkg::MS_PER_SEC);

        running_next = running_reg;
        on_ext_next  = on_ext_reg;
        saw_next     = saw_reg;
        unpl_next    = unpl_reg;
        last_next    = last_reg;
        sess_next    = sess_reg;
        since_next   = since_reg;

        if (s1_reg.kind == bcht_pkg::KIND_START || s1_reg.kind == bcht_pkg::KIND_POWER
            || s1_reg.kind == bcht_pkg::KIND_COMMIT)
        begin
            if (s1_reg.kind == bcht_pkg::KIND_START || !running_reg)
            begin
                running_next = 1'b1;
                on_ext_next  = s1_reg.external_power;
                saw_next     = s1_reg.external_power;
                unpl_next    = 1'b0;
                last_next    = s1_reg.now_ms;
                sess_next    = '0;
                since_next   = '0;
            end
            else if (on_ext_reg != s1_reg.external_power)
            begin
                sess_next   = acc_sess;
                on_ext_next = s1_reg.external_power;
                last_next   = s1_reg.now_ms;
                saw_next    = saw_reg || s1_reg.external_power;
                unpl_next   = !s1_reg.external_power;
                since_next  = '0;
            end
            else if (s1_reg.kind == bcht_pkg::KIND_COMMIT)
            begin
                sess_next  = acc_sess;
                since_next = acc_since;
                last_next  = acc_last;
            end
        end

        s2_next.item         = s1_reg;
        s2_next.sess_secs    = sess_next;
        s2_next.since_unplug = since_next;
        s2_next.unplugged    = unpl_next;
        s2_next.saw_external = saw_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            on_ext_reg  <= 1'b0;
            saw_reg     <= 1'b0;
            unpl_reg    <= 1'b0;
            last_reg    <= '0;
            sess_reg    <= '0;
            since_reg   <= '0;
        end
        else if (a_fire)
        begin
            running_reg <= running_next;
            on_ext_reg  <= on_ext_next;
            saw_reg     <= saw_next;
            unpl_reg    <= unpl_next;
            last_reg    <= last_next;
            sess_reg    <= sess_next;
            since_reg   <= since_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
            s2_reg <= s2_next;
    end

    // cycle stage: charge detection, cycle time and newest sample
    logic [31:0]      cs_reg, day_reg;
    logic             known_reg, conf_reg, pf_reg;
    logic [15:0]      sleep_reg, nmin_reg;
    logic [7:0]       kept_reg, pp_reg;
    logic [6:0]       npct_reg;
    logic [CNT_W-1:0] count_reg;

    logic [31:0]      cs_next, day_next;
    logic             known_next, conf_next, pf_next;
    logic [15:0]      sleep_next, nmin_next;
    logic [7:0]       kept_next, pp_next;
    logic [6:0]       npct_next;
    logic [CNT_W-1:0] count_next;

    bcht_pkg::item_t  b;
    logic             is_commit, valid_p, prev, seen, obs, inf, fresh, b_start, merr;
    logic             want, pf_eff;
    logic [7:0]       base, pp_eff;
    logic [15:0]      sleep_base, minutes;
    logic [31:0]      cs_add, cs_start, cs_new, min32;
    logic [63:0]      prod_min;
    bcht_pkg::result_t res_next, out_reg;

    always_comb
    begin
        b         = s2_reg.item;
        is_commit = (b.kind == bcht_pkg::KIND_COMMIT);
        valid_p   = b.measure_ok && (b.percent <= bcht_pkg::PCT_MAX);
        merr      = is_commit && !valid_p;
        cs_add    = bcht_pkg::sat_add32(cs_reg, s2_reg.sess_secs);
        prev      = kept_reg <= bcht_pkg::PCT_MAX;
        base      = (pf_reg && pp_reg <= bcht_pkg::PCT_MAX) ? pp_reg : kept_reg;
        seen      = pf_reg || s2_reg.saw_external;
        obs       = prev && !b.external_power && seen && base <= bcht_pkg::PCT_MAX
                    && b.percent >= base && (b.percent - base) >= {1'b0, orise_reg};
        inf       = prev && !b.external_power && b.percent >= kept_reg
                    && (b.percent - kept_reg) >= {1'b0, irise_reg};
        fresh     = obs || inf;
        b_start   = is_commit && valid_p && (!prev || fresh);
        cs_start  = (fresh && s2_reg.unplugged) ? s2_reg.since_unplug : s2_reg.sess_secs;
        cs_new    = b_start ? cs_start : cs_add;
        prod_min  = 64'(cs_new) * bcht_pkg::MAGIC_MIN;
        min32     = 32'(prod_min >> bcht_pkg::MIN_SHIFT);
        minutes   = (min32 > 32'(bcht_pkg::U16_MAX)) ? bcht_pkg::U16_MAX : min32[15:0];
        want      = (count_reg == '0)
                    || ({1'b0, npct_reg} >= {1'b0, drop_reg}
                        && b.percent <= {1'b0, npct_reg} - {1'b0, drop_reg});
        pf_eff    = b_start ? 1'b0 : pf_reg;
        pp_eff    = b_start ? bcht_pkg::PCT_NONE : pp_reg;
        sleep_base = b_start ? 16'd0 : sleep_reg;

        cs_next    = cs_reg;
        day_next   = day_reg;
        known_next = known_reg;
        conf_next  = conf_reg;
        pf_next    = pf_reg;
        pp_next    = pp_reg;
        sleep_next = sleep_reg;
        kept_next  = kept_reg;
        nmin_next  = nmin_reg;
        npct_next  = npct_reg;
        count_next = count_reg;

        if (is_commit)
        begin
            if (!valid_p)
            begin
                cs_next = cs_add;
                if (!known_reg && b.day_ok)
                begin
                    day_next   = b.day_index;
                    known_next = 1'b1;
                end
                if (b.external_power && prev)
                begin
                    pf_next = 1'b1;
                    pp_next = kept_reg;
                end
            end
            else
            begin
                cs_next   = cs_new;
                kept_next = b.percent;
                if (b_start)
                begin
                    conf_next  = fresh;
                    day_next   = b.day_ok ? b.day_index : 32'd0;
                    known_next = b.day_ok;
                    count_next = CNT_W'(1);
                    nmin_next  = minutes;
                    npct_next  = b.percent[6:0];
                end
                else if (want)
                begin
                    if (count_reg != '0 && nmin_reg == minutes)
                        npct_next = b.percent[6:0];
                    else if (count_reg < CNT_W'(SAMPLE_SLOTS))
                    begin
                        nmin_next  = minutes;
                        npct_next  = b.percent[6:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                if (b.external_power)
                begin
                    if (!pf_eff || pp_eff > bcht_pkg::PCT_MAX)
                        pp_next = b.percent;
                    else if (b.percent < pp_eff)
                        pp_next = b.percent;
                    else
                        pp_next = pp_eff;
                    pf_next = 1'b1;
                end
                else
                begin
                    pf_next = 1'b0;
                    pp_next = bcht_pkg::PCT_NONE;
                end
            end
            sleep_next = (sleep_base != bcht_pkg::U16_MAX) ? sleep_base + 16'd1 : sleep_base;
        end

        res_next.pad              = '0;
        res_next.start_day_known  = known_next;
        res_next.start_day        = day_next;
        res_next.measure_error    = merr;
        res_next.sleep_count      = sleep_next;
        res_next.charge_pending   = pf_next;
        res_next.cycle_confirmed  = conf_next;
        res_next.cycle_began      = b_start;
        res_next.previous_percent = kept_next;
        res_next.newest_percent   = npct_next;
        res_next.newest_minutes   = nmin_next;
        res_next.sample_count     = 6'(count_next);
        res_next.active_seconds   = cs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg    <= '0;
            day_reg   <= '0;
            known_reg <= 1'b0;
            conf_reg  <= 1'b0;
            pf_reg    <= 1'b0;
            pp_reg    <= bcht_pkg::PCT_NONE;
            sleep_reg <= '0;
            kept_reg  <= bcht_pkg::PCT_NONE;
            nmin_reg  <= '0;
            npct_reg  <= '0;
            count_reg <= '0;
        end
        else if (b_fire)
        begin
            cs_reg    <= cs_next;
            day_reg   <= day_next;
            known_reg <= known_next;
            conf_reg  <= conf_next;
            pf_reg    <= pf_next;
            pp_reg    <= pp_next;
            sleep_reg <= sleep_next;
            kept_reg  <= kept_next;
            nmin_reg  <= nmin_next;
            npct_reg  <= npct_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
            out_reg <= res_next;
    end

    assign m_tdata = out_reg;

    // checks
    `ASSERT_NEXT(a_start_one_sample, clk, rst_n, b_fire && b_start, count_reg == CNT_W'(1))
    `ASSERT_IMPL(a_conf_on_start, clk, rst_n, $rose(conf_reg), $past(b_fire && b_start))
    `ASSERT_IMPL(a_pending_pct, clk, rst_n, pf_reg, pp_reg <= bcht_pkg::PCT_MAX)
    `ASSERT_IMPL(a_full_stall, clk, rst_n, out_v_reg && !m_tready && s2_v_reg && s1_v_reg, !s_tready)

endmodule
